@@ src/spo_pkg.sv @@
// Shared package of the shuffled play order core.
// Field widths, function codes, default depth and the table control struct.
// No dependencies.
`default_nettype none

package spo_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int CFG_W           = 9;
	localparam int RND_W           = 16;
	localparam int OUT_W           = 8;

	localparam logic FUNC_SHUFFLE = 1'b0;
	localparam logic FUNC_NEXT    = 1'b1;

	// table port control, top level to table
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic restart;
	} tbl_ctl_t;

endpackage

`default_nettype wire

@@ src/shuffled_play_order_core.sv @@
// Shuffled play order core: permutation table with Fisher-Yates shuffle steps.
// Shuffle step: S_LAST on a round's first step, then S_DST, S_DIV (bit-serial modulo),
// S_RDJ, S_WR1, S_WR2, S_POST; j equal to n skips the swap, the last step adds fix-up.
// Next request: S_NDATA, then S_OUT; a count-of-one step goes S_LAST, S_OUT. One item at a time;
// the next request is taken once the result has moved to the output register.
// Reset is async, active low; after reset and every count write the table sweeps
`default_nettype none

module shuffled_play_order_core #(
	parameter int MAX_ENTRIES = spo_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// config write channel
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [spo_pkg::CFG_W-1:0] entry_count,
	// request channel
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      func,
	input  wire logic [spo_pkg::RND_W-1:0] random_word,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [spo_pkg::OUT_W-1:0]      entry,
	output logic [spo_pkg::OUT_W-1:0]      position,
	output logic                           round_end,
	output logic                           shuffle_done
);

	// identity order in, with in_stall high.

	// PW: table index / entry value width; CW: count width (holds MAX_ENTRIES)
	localparam int PW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int RESET_COUNT = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
	localparam int OW = spo_pkg::OUT_W;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_NDATA = 13'b0000000000010, // next request: table data arrives
		S_LAST  = 13'b0000000000100, // round start: old last entry arrives
		S_DST   = 13'b0000000001000, // kick the modulo unit
		S_DIV   = 13'b0000000010000, // wait for j
		S_RDJ   = 13'b0000000100000, // entry n arrives, read j
		S_WR1   = 13'b0000001000000, // entry j arrives, write slot n
		S_WR2   = 13'b0000010000000, // write slot j
		S_POST  = 13'b0000100000000, // step cursor or start fix-up check
		S_FX0   = 13'b0001000000000, // first entry arrives, compare
		S_FX1   = 13'b0010000000000, // middle entry arrives, write slot 0
		S_FX2   = 13'b0100000000000, // write middle slot
		S_OUT   = 13'b1000000000000  // hand result to output register
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   cursor_q;
	logic [PW-1:0]   old_last_q;
	logic [PW-1:0]   pos_q;
	logic            bf_q;
	logic [spo_pkg::RND_W-1:0] rnd_q;
	logic [PW-1:0]   j_q;
	logic [PW-1:0]   tmp_q;
	logic [PW-1:0]   res_entry_q;
	logic            res_done_q;

	logic            out_valid_q;
	logic [OW-1:0]   entry_q;
	logic [OW-1:0]   position_q;
	logic            round_end_q;
	logic            shuffle_done_q;

	spo_pkg::tbl_ctl_t tbl_ctl;
	logic [PW-1:0]   tbl_rd_addr;
	logic [PW-1:0]   tbl_wr_addr;
	logic [PW-1:0]   tbl_wr_data;
	logic [PW-1:0]   tbl_rd_data;
	logic            tbl_clearing;

	logic            div_start;
	logic            div_done;
	logic [CW-1:0]   div_rem;

	logic            cfg_wr;
	logic            in_acc;
	logic            out_load;
	logic [CW-1:0]   cfg_clamped;
	logic [CW-1:0]   pos_inc;
	logic [PW-1:0]   pos_next;
	logic [PW-1:0]   last_idx;
	logic [PW-1:0]   mid_idx;
	logic            is_last;
	logic [PW+OW-1:0] entry_ext;
	logic [PW+OW-1:0] pos_ext;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != S_IDLE) || tbl_clearing;
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// count register: 0 reads as 1, anything above the table depth as the depth
	always_comb begin
		if (entry_count == '0) begin
			cfg_clamped = CW'(1);
		end else if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
			cfg_clamped = CW'(MAX_ENTRIES);
		end else begin
			cfg_clamped = CW'(entry_count);
		end
	end

	assign last_idx = PW'(count_q - CW'(1));
	assign mid_idx  = PW'(count_q >> 1);
	assign pos_inc  = CW'(pos_q) + CW'(1);
	// play position advance; the first advance after reset or a count write lands on 0
	assign pos_next = (bf_q || (pos_inc == count_q)) ? '0 : PW'(pos_inc);
	assign is_last  = !bf_q && (CW'(pos_q) == (count_q - CW'(1)));

	// table port steering
	always_comb begin
		tbl_ctl         = '0;
		tbl_ctl.restart = cfg_wr;
		tbl_rd_addr     = cursor_q;
		tbl_wr_addr     = cursor_q;
		tbl_wr_data     = tmp_q;
		case (state_q)
			S_IDLE: begin
				tbl_ctl.rd_en = in_acc;
				tbl_rd_addr   = (func == spo_pkg::FUNC_NEXT) ? pos_next : last_idx;
			end
			S_DIV: begin
				tbl_ctl.rd_en = div_done;
				tbl_rd_addr   = cursor_q;
			end
			S_RDJ: begin
				tbl_ctl.rd_en = 1'b1;
				tbl_rd_addr   = j_q;
			end
			S_WR1: begin
				tbl_ctl.wr_en = 1'b1;
				tbl_wr_addr   = cursor_q;
				tbl_wr_data   = tbl_rd_data;
			end
			S_WR2: begin
				tbl_ctl.wr_en = 1'b1;
				tbl_wr_addr   = j_q;
				tbl_wr_data   = tmp_q;
			end
			S_POST: begin
				tbl_ctl.rd_en = (cursor_q <= PW'(1));
				tbl_rd_addr   = '0;
			end
			S_FX0: begin
				tbl_ctl.rd_en = 1'b1;
				tbl_rd_addr   = mid_idx;
			end
			S_FX1: begin
				tbl_ctl.wr_en = 1'b1;
				tbl_wr_addr   = '0;
				tbl_wr_data   = tbl_rd_data;
			end
			S_FX2: begin
				// slot 0 held the old last entry, so that is what moves to the middle
				tbl_ctl.wr_en = 1'b1;
				tbl_wr_addr   = mid_idx;
				tbl_wr_data   = old_last_q;
			end
			default: begin
				tbl_ctl.rd_en = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == S_DST);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= CW'(RESET_COUNT);
			cursor_q   <= '0;
			old_last_q <= '0;
			pos_q      <= '0;
			bf_q       <= 1'b1;
		end else if (cfg_wr) begin
			// new count: identity order, rewind, drop any running round
			state_q  <= S_IDLE;
			count_q  <= cfg_clamped;
			cursor_q <= '0;
			pos_q    <= '0;
			bf_q     <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (func == spo_pkg::FUNC_NEXT) begin
							pos_q   <= pos_next;
							bf_q    <= 1'b0;
							state_q <= S_NDATA;
						end else if (cursor_q == '0) begin
							state_q <= S_LAST;
						end else begin
							state_q <= S_DST;
						end
					end
				end
				S_NDATA: begin
					state_q <= S_OUT;
				end
				S_LAST: begin
					old_last_q <= tbl_rd_data;
					if (count_q < CW'(2)) begin
						// single entry: round is over at once
						state_q <= S_OUT;
					end else begin
						cursor_q <= last_idx;
						state_q  <= S_DST;
					end
				end
				S_DST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= (PW'(div_rem) == cursor_q) ? S_POST : S_RDJ;
					end
				end
				S_RDJ: begin
					state_q <= S_WR1;
				end
				S_WR1: begin
					state_q <= S_WR2;
				end
				S_WR2: begin
					state_q <= S_POST;
				end
				S_POST: begin
					if (cursor_q > PW'(1)) begin
						cursor_q <= cursor_q - PW'(1);
						state_q  <= S_OUT;
					end else begin
						cursor_q <= '0;
						state_q  <= S_FX0;
					end
				end
				S_FX0: begin
					state_q <= (tbl_rd_data == old_last_q) ? S_FX1 : S_OUT;
				end
				S_FX1: begin
					state_q <= S_FX2;
				end
				S_FX2: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working data, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rnd_q       <= random_word;
			res_entry_q <= '0;
			res_done_q  <= 1'b0;
		end
		if (div_done) begin
			j_q <= PW'(div_rem);
		end
		case (state_q)
			S_NDATA: res_entry_q <= tbl_rd_data;
			S_LAST:  res_done_q  <= (count_q < CW'(2));
			S_RDJ:   tmp_q       <= tbl_rd_data;
			S_POST:  res_done_q  <= (cursor_q <= PW'(1));
			default: begin
			end
		endcase
	end

	// output register: lets the next request start while a result waits
	assign entry_ext = {{OW{1'b0}}, res_entry_q};
	assign pos_ext   = {{OW{1'b0}}, pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			entry_q        <= entry_ext[OW-1:0];
			position_q     <= pos_ext[OW-1:0];
			round_end_q    <= is_last;
			shuffle_done_q <= res_done_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign entry        = entry_q;
	assign position     = position_q;
	assign round_end    = round_end_q;
	assign shuffle_done = shuffle_done_q;

	spo_table #(
		.DEPTH (MAX_ENTRIES),
		.AW    (PW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tbl_ctl),
		.rd_addr  (tbl_rd_addr),
		.wr_addr  (tbl_wr_addr),
		.wr_data  (tbl_wr_data),
		.rd_data  (tbl_rd_data),
		.clearing (tbl_clearing)
	);

	// j = random_word mod (n + 1)
	spo_mod_unit #(
		.DIV_W (CW),
		.NUM_W (spo_pkg::RND_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rnd_q),
		.divisor   (CW'(cursor_q) + CW'(1)),
		.done      (div_done),
		.remainder (div_rem)
	);

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(cursor_q) < count_q)
		else $error("swap cursor beyond entry count");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(pos_q) < count_q)
		else $error("play position beyond entry count");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("modulo result outside wait state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !cfg_wr) |=> in_stall)
		else $error("request taken without going busy");
`endif

endmodule

`default_nettype wire

@@ src/spo_mod_unit.sv @@
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Uses no package items; instantiated by the top level.
`default_nettype none

module spo_mod_unit #(
	parameter int DIV_W = 9,
	parameter int NUM_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      remainder
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [NUM_W-1:0] num_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;

	// partial remainder stays below divisor, so trial < 2 * divisor
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[DIV_W-1:0];
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ src/spo_table.sv @@
// Order table memory with one write and one registered read port.
// Sweeps identity order in after reset or a restart. Uses spo_pkg::tbl_ctl_t.
`default_nettype none

module spo_table #(
	parameter int DEPTH = spo_pkg::MAX_ENTRIES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spo_pkg::tbl_ctl_t ctl,
	input  wire logic [AW-1:0]     rd_addr,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [AW-1:0]     wr_data,
	output logic [AW-1:0]          rd_data,
	output logic                   clearing
);

	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rd_q;
	logic [AW-1:0] clr_q;
	logic          clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (ctl.restart) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= clr_q;
		end else if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

@@ verif/tb_shuffled_play_order_core.sv @@
// Self-checking testbench for shuffled_play_order_core: directed and random
// shuffle/next requests, count writes and handshake idling, scoreboard-checked.
// Depends on src/spo_pkg.sv and src/shuffled_play_order_core.sv.
`timescale 1ns / 1ps

// Tracks the permutation table, shuffle cursor and play position, and keeps
// the expected responses in request order.
class play_order_scoreboard;

	typedef struct packed {
		bit [spo_pkg::OUT_W-1:0] entry;
		bit [spo_pkg::OUT_W-1:0] position;
		bit                      round_end;
		bit                      shuffle_done;
	} play_result_t;

	bit [spo_pkg::OUT_W-1:0] order[spo_pkg::MAX_ENTRIES_DEF];
	int unsigned    count;
	int unsigned    cursor;
	int unsigned    play_pos;
	bit [spo_pkg::OUT_W-1:0] old_last;
	bit             before_first;
	play_result_t   expected_q[$];

	int unsigned    errors;
	int unsigned    shuffles;
	int unsigned    nexts;
	int unsigned    rounds_done;
	int unsigned    fixups;

	function new();
		count    = spo_pkg::MAX_ENTRIES_DEF;
		old_last = '0;
		restore_order();
	endfunction

	function void restore_order();
		for (int i = 0; i < spo_pkg::MAX_ENTRIES_DEF; i++)
			order[i] = i[spo_pkg::OUT_W-1:0];
		cursor       = 0;
		play_pos     = 0;
		before_first = 1'b1;
	endfunction

	// 0 reads as 1, anything past the table depth reads as the depth
	function void set_count(bit [spo_pkg::CFG_W-1:0] v);
		if (v == 0)
			count = 1;
		else if (v > spo_pkg::MAX_ENTRIES_DEF)
			count = spo_pkg::MAX_ENTRIES_DEF;
		else
			count = 32'(v);
		restore_order();
	endfunction

	function void swap_entries(int unsigned a, int unsigned b);
		bit [spo_pkg::OUT_W-1:0] t;
		t        = order[a];
		order[a] = order[b];
		order[b] = t;
	endfunction

	// one descending swap; returns 1 when the round (with fix-up) is finished
	function bit shuffle_step(bit [spo_pkg::RND_W-1:0] rnd);
		int unsigned n;
		int unsigned j;
		if (cursor == 0) begin
			old_last = order[count-1];
			if (count < 2)
				return 1'b1;
			cursor = count - 1;
		end
		n = cursor;
		if (n >= count)
			n = count - 1;
		j = rnd % (n + 1);
		if (j != n)
			swap_entries(n, j);
		if (n > 1) begin
			cursor = n - 1;
			return 1'b0;
		end
		cursor = 0;
		// keep the last entry of the old order from playing twice in a row
		if (order[0] == old_last) begin
			swap_entries(0, count / 2);
			fixups++;
		end
		return 1'b1;
	endfunction

	function void note_request(logic f, bit [spo_pkg::RND_W-1:0] rnd);
		play_result_t r;
		r = '0;
		if (f == spo_pkg::FUNC_SHUFFLE) begin
			shuffles++;
			r.shuffle_done = shuffle_step(rnd);
			if (r.shuffle_done)
				rounds_done++;
		end else begin
			nexts++;
			if (before_first) begin
				play_pos     = 0;
				before_first = 1'b0;
			end else begin
				play_pos = (play_pos + 1) % count;
			end
			r.entry = order[play_pos];
		end
		r.position  = play_pos[spo_pkg::OUT_W-1:0];
		r.round_end = !before_first && (play_pos == count - 1);
		expected_q.push_back(r);
	endfunction

	function void check_result(bit [spo_pkg::OUT_W-1:0] e, bit [spo_pkg::OUT_W-1:0] p,
		bit re, bit sd);
		play_result_t x;
		if (expected_q.size() == 0) begin
			$error("response with none outstanding: entry %0d position %0d", e, p);
			errors++;
			return;
		end
		x = expected_q.pop_front();
		if (e != x.entry) begin
			$error("entry: expected %0d, got %0d", x.entry, e);
			errors++;
		end
		if (p != x.position) begin
			$error("position: expected %0d, got %0d", x.position, p);
			errors++;
		end
		if (re != x.round_end) begin
			$error("round_end: expected %0d, got %0d", x.round_end, re);
			errors++;
		end
		if (sd != x.shuffle_done) begin
			$error("shuffle_done: expected %0d, got %0d", x.shuffle_done, sd);
			errors++;
		end
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction

	function int unsigned requests();
		return shuffles + nexts;
	endfunction

endclass

module tb_shuffled_play_order_core;

	localparam int RANDOM_ITEMS   = 1250;
	localparam int PHASE_ITEMS    = 40;
	// cycles with no handshake at all; a count write sweep and a shuffle step both
	// fit well inside it, stalls on top of that are short
	localparam int WATCHDOG_LIMIT = 5000;
	// a shuffle step with fix-up on the first step of a round
	localparam int DRAIN_CYCLES   = 40;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [spo_pkg::CFG_W-1:0]     entry_count;
	logic                          in_valid;
	logic                          in_stall;
	logic                          func;
	logic [spo_pkg::RND_W-1:0]     random_word;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [spo_pkg::OUT_W-1:0]     entry;
	logic [spo_pkg::OUT_W-1:0]     position;
	logic                          round_end;
	logic                          shuffle_done;

	play_order_scoreboard sb;

	int unsigned in_idle_pct;
	int unsigned out_stall_pct;
	int unsigned count_writes;

	// any handshake at this edge keeps the watchdog quiet
	wire any_accept = (in_valid && !in_stall) || (out_valid && !out_stall) ||
	                  (cfg_valid && cfg_ready);

	shuffled_play_order_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.entry_count  (entry_count),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.random_word  (random_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.entry        (entry),
		.position     (position),
		.round_end    (round_end),
		.shuffle_done (shuffle_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Response side: the outputs seen right after the edge are the values the
	// block held into it, so the handshake is judged on pre-edge state. The
	// stall for the next cycle is drawn fresh every cycle.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(entry, position, round_end, shuffle_done);
		out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (any_accept === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_shuffled_play_order_core: done, errors");
		$finish;
	end

	task automatic set_idle(idle_mode_e m);
		case (m)
			IDLE_NONE: begin
				in_idle_pct   = 0;
				out_stall_pct = 0;
			end
			IDLE_SENDER: begin
				in_idle_pct   = 82;
				out_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				in_idle_pct   = 0;
				out_stall_pct = 82;
			end
			default: begin
				in_idle_pct   = 21;
				out_stall_pct = 21;
			end
		endcase
	endtask

	// Valid stays high from one request to the next unless a gap is drawn,
	// so it is never dropped and raised within one time step.
	task automatic send_request(logic f, logic [spo_pkg::RND_W-1:0] rnd);
		if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_idle_pct)
				@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		random_word <= rnd;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_request(f, rnd);
	endtask

	// wait for every outstanding response with the request side quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// only called with nothing outstanding; the block then sweeps its table
	// and holds in_stall, which the next request simply waits out
	task automatic write_count(logic [spo_pkg::CFG_W-1:0] v);
		drain();
		cfg_valid   <= 1'b1;
		entry_count <= v;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		sb.set_count(v);
		count_writes++;
		cfg_valid <= 1'b0;
	endtask

	// small words land on j == n and j == 0 often for short lists
	function automatic logic [spo_pkg::RND_W-1:0] pick_word();
		if ($urandom_range(99) < 20)
			return spo_pkg::RND_W'($urandom_range(0, 3));
		return spo_pkg::RND_W'($urandom_range(0, 65535));
	endfunction

	// enough shuffle steps for a full round, from wherever the cursor stands, then a
	// play-through of the whole list and up to two entries more
	task automatic round_and_play();
		int unsigned steps;
		steps = (sb.count < 2) ? 1 : sb.count - 1;
		repeat (steps)
			send_request(spo_pkg::FUNC_SHUFFLE, pick_word());
		repeat (sb.count + $urandom_range(0, 2))
			send_request(spo_pkg::FUNC_NEXT, spo_pkg::RND_W'($urandom_range(0, 65535)));
	endtask

	initial begin
		int unsigned                 goal;
		int unsigned                 phase_no;
		int unsigned                 phase_start;
		int unsigned                 roll;
		logic [spo_pkg::CFG_W-1:0]   cnt;

		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		entry_count   = 9'd256;
		in_valid      = 1'b0;
		func          = spo_pkg::FUNC_SHUFFLE;
		random_word   = '0;
		count_writes  = 0;
		set_idle(IDLE_NONE);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// reset count: first next lands on position 0, shuffle steps with the
		// word extremes, a next in the middle of a round
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);
		send_request(spo_pkg::FUNC_NEXT, 16'hFFFF);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'h0000);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'hFFFF);
		send_request(spo_pkg::FUNC_NEXT, 16'h5A5A);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'h8000);

		// count of one: a shuffle step finishes at once, table untouched
		write_count(9'd1);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'hFFFF);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);

		// count of two: word 0 swaps, the old last entry comes first, so the
		// fix-up swaps it back; word 1 leaves the table alone
		write_count(9'd2);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'h0000);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'h0001);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);

		// zero reads as one, all-ones reads as the full table
		write_count(9'd0);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'h1234);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);
		write_count(9'h1FF);
		send_request(spo_pkg::FUNC_NEXT, 16'h0000);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'hFFFF);
		send_request(spo_pkg::FUNC_SHUFFLE, 16'h0000);

		// --- random part ---
		// each phase writes a count and runs under one idling mode; mostly
		// complete rounds and play-throughs, the rest scattered requests
		goal     = sb.requests() + RANDOM_ITEMS;
		phase_no = 0;
		while (sb.requests() < goal) begin
			set_idle(idle_mode_e'(phase_no % 4));
			roll = $urandom_range(99);
			if (phase_no == 1)
				cnt = 9'd256;
			else if (roll < 80)
				cnt = spo_pkg::CFG_W'($urandom_range(1, 16));
			else if (roll < 92)
				cnt = spo_pkg::CFG_W'($urandom_range(17, 64));
			else
				cnt = spo_pkg::CFG_W'($urandom_range(0, 511));
			write_count(cnt);
			phase_start = sb.requests();
			while (sb.requests() - phase_start < PHASE_ITEMS && sb.requests() < goal) begin
				if ($urandom_range(99) < 70)
					round_and_play();
				else
					repeat ($urandom_range(1, 8))
						send_request(1'($urandom_range(0, 1)), pick_word());
			end
			phase_no++;
		end

		// --- wind-down ---
		set_idle(IDLE_NONE);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending() != 0)
			$error("%0d responses never arrived", sb.pending());
		$display("covered %0d requests: %0d shuffle steps, %0d next, %0d rounds finished",
			sb.requests(), sb.shuffles, sb.nexts, sb.rounds_done);
		$display("with %0d fix-up swaps across %0d count writes and %0d random phases",
			sb.fixups, count_writes, phase_no);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_shuffled_play_order_core: done, clean");
		else
			$display("tb_shuffled_play_order_core: done, errors");
		$finish;
	end

endmodule

@@ shuffled_play_order_core.f @@
src/spo_pkg.sv
src/spo_mod_unit.sv
src/spo_table.sv
src/shuffled_play_order_core.sv
verif/tb_shuffled_play_order_core.sv
